[rtl/pidl_pkg.sv]
// shared types and constants for the positional insert/delete list
`timescale 1ns / 1ps

package pidl_pkg;

   // width of one list entry
   localparam int PIDL_DATA_W = 32;

   // default list capacity
   localparam int PIDL_DEPTH_DEF = 128;

   // operation codes carried by a request
   typedef enum logic [2:0] {
      OP_INS_AT  = 3'd0,
      OP_INS_END = 3'd1,
      OP_DEL_AT  = 3'd2,
      OP_DEL_END = 3'd3,
      OP_READ    = 3'd4
   } pidl_op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_INDEX = 2'd3
   } pidl_status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INS,
      CMD_DEL,
      CMD_ROT
   } pidl_cmd_type;

   // controller states
   typedef enum logic {
      S_IDLE,
      S_ROTATE
   } pidl_state_type;

endpackage

[rtl/pidl_cell.sv]
// one cell of the list chain: holds one entry and trades it with its neighbors
`timescale 1ns / 1ps

module pidl_cell
   import pidl_pkg::*;
#(
   parameter int DEPTH = PIDL_DEPTH_DEF,
   parameter int POS = 0,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  pidl_cmd_type           cmd_kind,
   input  logic [CNT_W-1:0]       cmd_pos,
   input  logic [CNT_W-1:0]       cmd_count,
   input  logic [PIDL_DATA_W-1:0] cmd_value,
   input  logic [PIDL_DATA_W-1:0] left_data,
   input  logic [PIDL_DATA_W-1:0] right_data,
   input  logic [PIDL_DATA_W-1:0] head_data,
   output logic [PIDL_DATA_W-1:0] data_out
);

   localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);
   localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(POS + 1);

   logic [PIDL_DATA_W-1:0] data_ff;
   logic [PIDL_DATA_W-1:0] data_in;

   // pick this cell's next entry from the broadcast command
   always_comb begin
      data_in = data_ff;
      case (cmd_kind)
         CMD_INS: begin
            if (POS_C == cmd_pos) begin
               data_in = cmd_value;
            end else if (POS_C > cmd_pos) begin
               data_in = left_data;
            end
         end
         CMD_DEL: begin
            if (POS_C >= cmd_pos) begin
               data_in = right_data;
            end
         end
         CMD_ROT: begin
            // rotate the occupied part toward the head, last slot takes the head
            if (POS_NEXT < cmd_count) begin
               data_in = right_data;
            end else if (POS_NEXT == cmd_count) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

[rtl/pidl_ctrl.sv]
// list controller: request decode, count, read rotation and result staging
`timescale 1ns / 1ps

module pidl_ctrl
   import pidl_pkg::*;
#(
   parameter int DEPTH = PIDL_DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic [CNT_W-1:0]              req_index,
   input  logic signed [PIDL_DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [CNT_W-1:0]              rsp_count,
   output logic signed [PIDL_DATA_W-1:0] rsp_read_value,
   input  logic [PIDL_DATA_W-1:0]        head_data,
   output pidl_cmd_type                  cmd_kind,
   output logic [CNT_W-1:0]              cmd_pos,
   output logic [CNT_W-1:0]              cmd_count,
   output logic [PIDL_DATA_W-1:0]        cmd_value
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   pidl_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rot_ff, rot_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [PIDL_DATA_W-1:0] rd_val_ff, rd_val_in;

   // result staging: output register plus one skid entry
   logic                   rsp_valid_ff;
   pidl_status_type        rsp_status_ff;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic [PIDL_DATA_W-1:0] rsp_value_ff;
   logic                   res_valid_ff;
   pidl_status_type        res_status_ff;
   logic [CNT_W-1:0]       res_count_ff;
   logic [PIDL_DATA_W-1:0] res_value_ff;

   logic                   done_valid;
   pidl_status_type        done_status;
   logic [PIDL_DATA_W-1:0] done_value;

   logic        accept;
   logic        rsp_free;
   logic        read_ok;
   logic        rot_last;
   logic        is_full;
   logic        is_empty;
   pidl_op_type op;

   assign op       = pidl_op_type'(req_op);
   assign req_stall = (state_ff != S_IDLE) || res_valid_ff;
   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign is_full  = (count_ff == DEPTH_C);
   assign is_empty = (count_ff == '0);
   assign read_ok  = (op == OP_READ) && !is_empty && (req_index < count_ff);
   assign rot_last = (rot_ff == count_ff - ONE_C);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && read_ok) begin
               state_in = S_ROTATE;
            end
         end
         S_ROTATE: begin
            if (rot_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // cell commands, count update and results
   always_comb begin
      cmd_kind    = CMD_HOLD;
      cmd_pos     = req_index;
      cmd_value   = req_value;
      count_in    = count_ff;
      rot_in      = rot_ff;
      rd_idx_in   = rd_idx_ff;
      rd_val_in   = rd_val_ff;
      done_valid  = 1'b0;
      done_status = STAT_OK;
      done_value  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_INS_AT, OP_INS_END: begin
                     done_valid = 1'b1;
                     if (op == OP_INS_END) begin
                        cmd_pos = count_ff;
                     end
                     if (is_full) begin
                        done_status = STAT_FULL;
                     end else if (cmd_pos > count_ff) begin
                        done_status = STAT_INDEX;
                     end else begin
                        cmd_kind = CMD_INS;
                        count_in = count_ff + ONE_C;
                     end
                  end
                  OP_DEL_AT, OP_DEL_END: begin
                     done_valid = 1'b1;
                     if (op == OP_DEL_END) begin
                        cmd_pos = count_ff - ONE_C;
                     end
                     if (is_empty) begin
                        done_status = STAT_EMPTY;
                     end else if (cmd_pos >= count_ff) begin
                        done_status = STAT_INDEX;
                     end else begin
                        cmd_kind = CMD_DEL;
                        count_in = count_ff - ONE_C;
                     end
                  end
                  OP_READ: begin
                     if (is_empty) begin
                        done_valid  = 1'b1;
                        done_status = STAT_EMPTY;
                     end else if (req_index >= count_ff) begin
                        done_valid  = 1'b1;
                        done_status = STAT_INDEX;
                     end else begin
                        rot_in    = '0;
                        rd_idx_in = req_index;
                     end
                  end
                  default: begin
                     done_valid  = 1'b1;
                     done_status = STAT_INDEX;
                  end
               endcase
            end
         end
         S_ROTATE: begin
            // entry rot_ff sits in the head cell now
            cmd_kind = CMD_ROT;
            rot_in   = rot_ff + ONE_C;
            if (rot_ff == rd_idx_ff) begin
               rd_val_in = head_data;
            end
            if (rot_last) begin
               done_valid = 1'b1;
               done_value = (rot_ff == rd_idx_ff) ? head_data : rd_val_ff;
            end
         end
         default: begin
            cmd_kind = CMD_HOLD;
         end
      endcase
   end

   assign cmd_count = count_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_free) begin
            rsp_valid_ff <= res_valid_ff || done_valid;
            res_valid_ff <= res_valid_ff && done_valid;
         end else if (done_valid) begin
            res_valid_ff <= 1'b1;
         end
      end
   end

   // read sequencer and result payload
   always_ff @(posedge clock) begin
      rot_ff    <= rot_in;
      rd_idx_ff <= rd_idx_in;
      rd_val_ff <= rd_val_in;
      if (rsp_free) begin
         if (res_valid_ff) begin
            rsp_status_ff <= res_status_ff;
            rsp_count_ff  <= res_count_ff;
            rsp_value_ff  <= res_value_ff;
            res_status_ff <= done_status;
            res_count_ff  <= count_in;
            res_value_ff  <= done_value;
         end else begin
            rsp_status_ff <= done_status;
            rsp_count_ff  <= count_in;
            rsp_value_ff  <= done_value;
         end
      end else if (done_valid) begin
         res_status_ff <= done_status;
         res_count_ff  <= count_in;
         res_value_ff  <= done_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_value_ff;

`ifndef SYNTHESIS
   // count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count beyond capacity");

   // rotation step stays inside the occupied part
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE) |-> (rot_ff < count_ff))
      else $error("rotation step beyond count");

   // skid entry only fills behind a held output
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output");

   // every accepted request yields a result or starts a read rotation
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || (state_ff == S_ROTATE)))
      else $error("accepted request produced nothing");

   // no request taken while a read rotation runs
   a_no_accept_rotate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE) |-> !accept)
      else $error("request accepted during rotation");
`endif

endmodule

[rtl/positional_insert_delete_list_top.sv]
// top level of the positional insert/delete list: controller and chain of cells
`timescale 1ns / 1ps

// Positional insert/delete list of up to DEPTH signed 32-bit entries.
// Request channel (req_valid / req_stall): req_op selects insert at index,
// insert at end, delete at index, delete at end or read; req_index and
// req_value go with it. A request is taken on a clock edge with req_valid
// high and req_stall low.
// Result channel (rsp_valid / rsp_stall): one result per request, with
// rsp_status, rsp_count (count after the operation) and rsp_read_value.
// Inserts, deletes and rejected requests finish in the cycle they are taken;
// the result goes to the output register, or to the skid entry while the
// output is held. All cells shift at once. A read rotates the occupied
// entries through the head cell, one step a cycle, until the list is back in
// place; its result is then registered, and no request is taken meanwhile.
// An output register plus one skid entry hold results while rsp_stall is
// high; req_stall rises once the skid entry is occupied.
// Reset (synchronous, active high) empties the list and drops pending results;
// entry contents are not cleared.

module positional_insert_delete_list_top
   import pidl_pkg::*;
#(
   parameter int DEPTH = PIDL_DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic [CNT_W-1:0]              req_index,
   input  logic signed [PIDL_DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [CNT_W-1:0]              rsp_count,
   output logic signed [PIDL_DATA_W-1:0] rsp_read_value
);

   pidl_cmd_type           cmd_kind;
   logic [CNT_W-1:0]       cmd_pos;
   logic [CNT_W-1:0]       cmd_count;
   logic [PIDL_DATA_W-1:0] cmd_value;
   logic [PIDL_DATA_W-1:0] cell_data [DEPTH];

   // request decode, count and result staging
   pidl_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value),
      .head_data      (cell_data[0]),
      .cmd_kind       (cmd_kind),
      .cmd_pos        (cmd_pos),
      .cmd_count      (cmd_count),
      .cmd_value      (cmd_value)
   );

   // chain of cells, each wired to both neighbors and to the head
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [PIDL_DATA_W-1:0] left_data;
      logic [PIDL_DATA_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = cell_data[0];
      end else begin : g_left
         assign left_data = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_right
         assign right_data = cell_data[g+1];
      end

      pidl_cell #(
         .DEPTH(DEPTH),
         .POS  (g)
      ) u_cell (
         .clock      (clock),
         .cmd_kind   (cmd_kind),
         .cmd_pos    (cmd_pos),
         .cmd_count  (cmd_count),
         .cmd_value  (cmd_value),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[g])
      );
   end

endmodule

[bench/tb_positional_insert_delete_list_top.sv]
// testbench for the positional insert/delete list: directed table, random op mix, shadow list
`timescale 1ns / 1ps

module tb_positional_insert_delete_list_top
   import pidl_pkg::*;
();

   localparam int DEPTH = PIDL_DEPTH_DEF;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 1680;
   localparam int PHASE_ITEMS = RANDOM_ITEMS / 4;
   localparam int PRESSURE_AT = 120;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_HEAVY = 77;
   localparam int IDLE_LIGHT = 23;

   // op codes the block does not define
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // one result as the block reports it
   typedef struct packed {
      pidl_status_type status;
      logic [CNT_W-1:0] count;
      logic [PIDL_DATA_W-1:0] read_value;
   } list_result_type;

   // one request, with a typed expectation where typed is set
   typedef struct packed {
      logic [2:0] op;
      logic [CNT_W-1:0] index;
      logic [PIDL_DATA_W-1:0] value;
      logic typed;
      list_result_type result;
   } stimulus_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_op;
   logic [CNT_W-1:0] req_index;
   logic signed [PIDL_DATA_W-1:0] req_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic [CNT_W-1:0] rsp_count;
   logic signed [PIDL_DATA_W-1:0] rsp_read_value;

   // shadow copy of the list
   logic [PIDL_DATA_W-1:0] shadow_entries [DEPTH];
   int shadow_count;

   list_result_type awaited_results [$];
   stimulus_row_type directed_rows [$];
   int mismatch_count;
   int send_idle_pct;
   int stall_pct;
   int hold_left;

   positional_insert_delete_list_top #(
      .DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_read_value(rsp_read_value)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // apply one request to the shadow list and return the result it gives
   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic [CNT_W-1:0] idx,
                                                     input logic [PIDL_DATA_W-1:0] val);
      list_result_type res;
      int pos;
      int i;
      res.status = STAT_OK;
      res.read_value = '0;
      case (op)
         OP_INS_AT, OP_INS_END: begin
            // full is checked before the index
            if (shadow_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               pos = (op == OP_INS_END) ? shadow_count : int'(idx);
               if (pos > shadow_count) begin
                  res.status = STAT_INDEX;
               end else begin
                  for (i = shadow_count; i > pos; i--) begin
                     shadow_entries[i] = shadow_entries[i-1];
                  end
                  shadow_entries[pos] = val;
                  shadow_count++;
               end
            end
         end
         OP_DEL_AT, OP_DEL_END: begin
            // empty is checked before the index
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               pos = (op == OP_DEL_END) ? shadow_count - 1 : int'(idx);
               if (pos >= shadow_count) begin
                  res.status = STAT_INDEX;
               end else begin
                  for (i = pos; i + 1 < shadow_count; i++) begin
                     shadow_entries[i] = shadow_entries[i+1];
                  end
                  shadow_count--;
               end
            end
         end
         OP_READ: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else if (int'(idx) >= shadow_count) begin
               res.status = STAT_INDEX;
            end else begin
               res.read_value = shadow_entries[idx];
            end
         end
         default: begin
            res.status = STAT_INDEX;
         end
      endcase
      res.count = CNT_W'(shadow_count);
      return res;
   endfunction

   // offer one request, wait for it to be taken, then record what it should return
   task automatic push_request(input stimulus_row_type row);
      list_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= row.op;
      req_index <= row.index;
      req_value <= row.value;
      do @(posedge clock); while (req_stall);
      res = apply_list_op(row.op, row.index, row.value);
      awaited_results.push_back(row.typed ? row.result : res);
   endtask

   // receiver: random stall, or a counted hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // compare each accepted result with the oldest one awaited
   always @(posedge clock) begin : result_check
      list_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d count %0d value %h",
                                      rsp_status, rsp_count, rsp_read_value));
         end else begin
            due = awaited_results.pop_front();
            if (rsp_status !== due.status)
               report_mismatch($sformatf("status %0d, awaited %0d", rsp_status, due.status));
            if (rsp_count !== due.count)
               report_mismatch($sformatf("count %0d, awaited %0d", rsp_count, due.count));
            if (rsp_read_value !== due.read_value)
               report_mismatch($sformatf("read value %h, awaited %h",
                                         rsp_read_value, due.read_value));
         end
      end
   end

   // stimulus
   initial begin
      stimulus_row_type row;
      bit growing;
      int n;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_READ;
      req_index = '0;
      req_value = '0;
      mismatch_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      shadow_count = 0;
      growing = 1'b1;

      // directed table: empty list, extremes, bad indexes, spare op codes
      directed_rows.push_back('{OP_READ, 8'd0, 32'h0, 1'b1, '{STAT_EMPTY, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_DEL_AT, 8'd0, 32'h0, 1'b1, '{STAT_EMPTY, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_DEL_END, 8'd0, 32'h0, 1'b1, '{STAT_EMPTY, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd1, 32'h1, 1'b1, '{STAT_INDEX, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd0, 32'h8000_0000, 1'b1, '{STAT_OK, 8'd1, 32'h0}});
      directed_rows.push_back('{OP_INS_END, 8'd255, 32'h7fff_ffff, 1'b1,
                                '{STAT_OK, 8'd2, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd1, 32'hffff_ffff, 1'b1, '{STAT_OK, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_READ, 8'd0, 32'h0, 1'b1, '{STAT_OK, 8'd3, 32'h8000_0000}});
      directed_rows.push_back('{OP_READ, 8'd1, 32'h0, 1'b1, '{STAT_OK, 8'd3, 32'hffff_ffff}});
      directed_rows.push_back('{OP_READ, 8'd2, 32'h0, 1'b1, '{STAT_OK, 8'd3, 32'h7fff_ffff}});
      directed_rows.push_back('{OP_READ, 8'd3, 32'h0, 1'b1, '{STAT_INDEX, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_READ, 8'd255, 32'h0, 1'b1, '{STAT_INDEX, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd3, 32'h5, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd255, 32'h9, 1'b1, '{STAT_INDEX, 8'd4, 32'h0}});
      directed_rows.push_back('{OP_DEL_AT, 8'd4, 32'h0, 1'b1, '{STAT_INDEX, 8'd4, 32'h0}});
      directed_rows.push_back('{OP_DEL_AT, 8'd0, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_SPARE_5, 8'd0, 32'h0, 1'b1, '{STAT_INDEX, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_SPARE_6, 8'd1, 32'h1234_5678, 1'b1,
                                '{STAT_INDEX, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_SPARE_7, 8'd255, 32'hffff_ffff, 1'b1,
                                '{STAT_INDEX, 8'd3, 32'h0}});
      directed_rows.push_back('{OP_DEL_END, 8'd0, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_READ, 8'd1, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_INS_AT, 8'd0, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_DEL_AT, 8'd1, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_READ, 8'd0, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});
      directed_rows.push_back('{OP_DEL_END, 8'd7, 32'h0, 1'b0, '{STAT_OK, 8'd0, 32'h0}});

      // reset
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         push_request(directed_rows[i]);
      end

      // random ops, swinging the list between empty and full
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            case (n / PHASE_ITEMS)
               0: begin
                  send_idle_pct = 0;
                  stall_pct = 0;
               end
               1: begin
                  send_idle_pct = IDLE_HEAVY;
                  stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  stall_pct = IDLE_HEAVY;
               end
               default: begin
                  send_idle_pct = IDLE_LIGHT;
                  stall_pct = IDLE_LIGHT;
               end
            endcase
         end
         // long receiver hold-off so the block backs up into the request side
         if (n == PRESSURE_AT)
            hold_left = HOLD_CYCLES;

         if (growing && shadow_count == DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && shadow_count == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;

         // op mix leans toward inserts or deletes
         pick = $urandom_range(0, 99);
         if (growing)
            row.op = (pick < 40) ? OP_INS_AT : (pick < 60) ? OP_INS_END :
                     (pick < 72) ? OP_DEL_AT : (pick < 78) ? OP_DEL_END :
                     (pick < 94) ? OP_READ : 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
         else
            row.op = (pick < 10) ? OP_INS_AT : (pick < 18) ? OP_INS_END :
                     (pick < 48) ? OP_DEL_AT : (pick < 70) ? OP_DEL_END :
                     (pick < 94) ? OP_READ : 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));

         // index: mostly in range, some at the boundary, some anywhere
         pick = $urandom_range(0, 9);
         if (pick == 0)
            row.index = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
         else if (row.op == OP_INS_AT || row.op == OP_INS_END)
            row.index = CNT_W'((pick == 1) ? shadow_count : $urandom_range(0, shadow_count));
         else if (shadow_count == 0)
            row.index = '0;
         else
            row.index = CNT_W'((pick == 1) ? shadow_count - 1
                                           : $urandom_range(0, shadow_count - 1));

         // value: mostly random, sometimes an extreme
         case ($urandom_range(0, 19))
            0: row.value = 32'h8000_0000;
            1: row.value = 32'h7fff_ffff;
            2: row.value = 32'hffff_ffff;
            3: row.value = 32'h0;
            default: row.value = $urandom;
         endcase
         row.typed = 1'b0;
         row.result = '0;
         push_request(row);
      end
      req_valid <= 1'b0;

      // drain, then give a full read rotation for stray results
      stall_pct = 0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
